// ===== src/wsor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsor_pkg
// Shared types and constants for the window statistics / outlier reject block.
// ----------------------------------------------------------------------------
package wsor_pkg;

    // window depth; a power of two so the mean and variance scale by shifts
    localparam int WINDOW_DEPTH = 64;
    localparam int LOG_DEPTH    = $clog2(WINDOW_DEPTH);

    // fixed field widths
    localparam int Q_W     = 24;
    localparam int KEPT_W  = 7;
    localparam int FLOOR_W = 8;
    localparam int PORT_SW = 16;

    // configuration register indexes (paddr[2])
    localparam logic REG_FLOOR   = 1'b0;
    localparam logic REG_MINKEPT = 1'b1;

    // configuration reset values
    localparam logic [FLOOR_W-1:0] FLOOR_RST   = 8'd2;
    localparam logic [KEPT_W-1:0]  MINKEPT_RST = 7'd52;

    // back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== src/wsor_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsor_front
// Input side: takes items, trims the sample and pushes it into the queue.
// ----------------------------------------------------------------------------
module wsor_front import wsor_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PORT_SW-1:0]     sample,
    input  logic                   q_full,
    input  back_status_t           bstat,
    output logic                   push,
    output logic [SAMPLE_BITS-1:0] push_data
);

    // hold off while the queue is full or the window is being cleared
    assign in_stall  = q_full | bstat.clearing;
    assign push      = in_valid & ~in_stall;
    // only the low sample bits enter the window
    assign push_data = sample[SAMPLE_BITS-1:0];

endmodule

// ===== src/wsor_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsor_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module wsor_queue #(
    parameter int W     = 16,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  data_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/wsor_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsor_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsor_div #(
    parameter int DVW = 62,
    parameter int DSW = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CNW = $clog2(DVW);

    logic [DSW-1:0] rem_reg;
    logic [DVW-1:0] quo_reg;
    logic [DSW-1:0] dsr_reg;
    logic [CNW-1:0] cnt_reg;
    logic           run_reg;
    logic           done_reg;

    logic [DSW:0]   trial;
    logic [DSW:0]   diff;
    logic           ge;

    // trial subtraction
    assign trial = {rem_reg, quo_reg[DVW-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(DVW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
            quo_reg <= {quo_reg[DVW-2:0], ge};
        end
    end

endmodule

// ===== src/wsor_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsor_back
// Back end: window memory, statistic passes, divide, square root, result.
// ----------------------------------------------------------------------------
module wsor_back import wsor_pkg::*; #(
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [SAMPLE_BITS-1:0] q_data,
    output logic                   q_pop,
    output back_status_t           bstat,
    input  logic [FLOOR_W-1:0]     outlier_floor,
    input  logic [KEPT_W-1:0]      min_kept_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [Q_W-1:0]         window_mean,
    output logic [PORT_SW-1:0]     window_min,
    output logic [PORT_SW-1:0]     window_max,
    output logic [Q_W-1:0]         window_stdev,
    output logic [Q_W-1:0]         filtered_mean,
    output logic [KEPT_W-1:0]      kept_count,
    output logic                   fell_back
);

    localparam int N   = WINDOW_DEPTH;
    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(N);
    localparam int CW  = $clog2(N + 1);
    localparam int SW  = SB + CW;
    localparam int QW  = 2 * SB + CW;
    localparam int DW  = 2 * SW;
    localparam int DVW = SW + 8;
    localparam int DSW = CW;
    localparam int VW  = 2 * SB + 16;
    localparam int MW  = SB + 8;
    localparam int FW  = SW + FLOOR_W;
    localparam int EW  = (CW > KEPT_W) ? CW : KEPT_W;

    localparam logic [SW-1:0]     N_SW  = SW'(N);
    localparam logic [DW-1:0]     N_DW  = DW'(N);
    localparam logic [FW-1:0]     N_FW  = FW'(N);
    localparam logic [CW-1:0]     N_CW  = CW'(N);
    localparam logic [KEPT_W-1:0] FB_K  = KEPT_W'((N > 127) ? 127 : N);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDOLD, S_P1, S_D1, S_D2, S_VAR,
        S_SQ, S_P2, S_DEC, S_DF_GO, S_DF_WAIT, S_OUT
    } state_t;

    state_t         state_reg;

    // window memory
    logic [SB-1:0]  mem [N];
    logic [SB-1:0]  rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  wr_addr;
    logic [SB-1:0]  wr_data;

    // sequencing and accumulators
    logic [CW-1:0]  iss_reg;
    logic [AW-1:0]  wp_reg;
    logic [SB-1:0]  x_reg;
    logic [SW-1:0]  sum_reg;
    logic [QW-1:0]  sumsq_reg;
    logic [SB-1:0]  min_reg;
    logic [SB-1:0]  max_reg;
    logic [2*SB-1:0] sq_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic [SW-1:0]  e_reg;
    logic [SB-1:0]  kv1_reg;
    logic [SB-1:0]  kv2_reg;
    logic [DW-1:0]  esq_reg;
    logic           flr_reg;
    logic [SW-1:0]  ksum_reg;
    logic [CW-1:0]  kcnt_reg;
    logic [DW-1:0]  ss_reg;
    logic [DW-1:0]  nq_reg;
    logic [DW-1:0]  d_reg;
    logic [MW-1:0]  mean_reg;
    logic [MW-1:0]  std_reg;
    logic [MW-1:0]  fmean_reg;
    logic [KEPT_W-1:0] kout_reg;
    logic           fb_reg;

    // square root
    logic [VW-1:0]  sqv_reg;
    logic [VW-1:0]  sqres_reg;
    logic [VW-1:0]  sqbit_reg;
    logic [VW:0]    sq_t;
    logic           sq_ge;

    // output stage
    logic           outv_reg;
    logic [Q_W-1:0] o_mean_reg;
    logic [PORT_SW-1:0] o_min_reg;
    logic [PORT_SW-1:0] o_max_reg;
    logic [Q_W-1:0] o_std_reg;
    logic [Q_W-1:0] o_fmean_reg;
    logic [KEPT_W-1:0] o_kept_reg;
    logic           o_fb_reg;

    // divider hookup
    logic           div_start;
    logic [DVW-1:0] div_dividend;
    logic [DSW-1:0] div_divisor;
    logic           div_done;
    logic [DVW-1:0] div_quo;

    // scaled mean and variance (depth is a power of two)
    logic [SW+7:0]  mean_sh;
    logic [DW+15:0] var_sh;

    // pass datapath
    logic [SW-1:0]  nv;
    logic [SW-1:0]  e_abs;
    logic [FW-1:0]  flim;
    logic [DW+1:0]  dev4;
    logic           pass_end;
    logic           keep;
    logic [EW-1:0]  kcnt_ext;
    logic           kcnt_low;

    assign bstat.clearing = (state_reg == S_CLEAR);
    assign q_pop          = (state_reg == S_IDLE) && !q_empty;

    // memory ports
    assign rd_addr = (state_reg == S_IDLE) ? wp_reg : iss_reg[AW-1:0];
    assign mem_we  = (state_reg == S_CLEAR) || (state_reg == S_RDOLD);
    assign wr_addr = (state_reg == S_CLEAR) ? iss_reg[AW-1:0] : wp_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : x_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // mean in Q.8 and variance in Q.16 by shifting out N and N^2
    assign mean_sh = {sum_reg, 8'h00} >> LOG_DEPTH;
    assign var_sh  = {d_reg, 16'h0000} >> (2 * LOG_DEPTH);

    // distance from the mean, scaled by N
    assign nv    = SW'(rdata_reg) * N_SW;
    assign e_abs = (nv >= sum_reg) ? nv - sum_reg : sum_reg - nv;
    assign flim  = FW'(outlier_floor) * N_FW;
    assign dev4  = {d_reg, 2'b00};
    assign keep  = ({2'b00, esq_reg} <= dev4) || flr_reg;

    assign pass_end = (iss_reg == N_CW) && !v1_reg && !v2_reg && !v3_reg;

    assign kcnt_ext = EW'(kcnt_reg);
    assign kcnt_low = (kcnt_ext < EW'(min_kept_count));

    // square root step
    assign sq_t  = {1'b0, sqres_reg} + {1'b0, sqbit_reg};
    assign sq_ge = ({1'b0, sqv_reg} >= sq_t);

    // divider only serves the kept-sample mean
    assign div_start    = (state_reg == S_DF_GO);
    assign div_dividend = {ksum_reg, 8'h00};
    assign div_divisor  = kcnt_reg;

    wsor_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            iss_reg   <= '0;
            wp_reg    <= '0;
            sum_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            // result taken; S_OUT handles its own valid
            if (outv_reg && !out_stall && state_reg != S_OUT)
            begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (iss_reg == CW'(N - 1))
                    begin
                        iss_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        x_reg     <= q_data;
                        state_reg <= S_RDOLD;
                    end
                end
                S_RDOLD:
                begin
                    sum_reg   <= sum_reg - SW'(rdata_reg) + SW'(x_reg);
                    wp_reg    <= (wp_reg == AW'(N - 1)) ? '0 : wp_reg + 1'b1;
                    iss_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    sumsq_reg <= '0;
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    if (iss_reg != N_CW)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    v1_reg <= (iss_reg != N_CW);
                    v2_reg <= v1_reg;
                    v3_reg <= 1'b0;
                    if (v1_reg)
                    begin
                        if (rdata_reg < min_reg)
                        begin
                            min_reg <= rdata_reg;
                        end
                        if (rdata_reg > max_reg)
                        begin
                            max_reg <= rdata_reg;
                        end
                        sq_reg <= (2*SB)'(rdata_reg) * (2*SB)'(rdata_reg);
                    end
                    if (v2_reg)
                    begin
                        sumsq_reg <= sumsq_reg + QW'(sq_reg);
                    end
                    if (pass_end)
                    begin
                        state_reg <= S_D1;
                    end
                end
                S_D1:
                begin
                    ss_reg    <= DW'(sum_reg) * DW'(sum_reg);
                    nq_reg    <= DW'(sumsq_reg) * N_DW;
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    // N^2 times the variance
                    d_reg     <= nq_reg - ss_reg;
                    mean_reg  <= mean_sh[MW-1:0];
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    sqv_reg   <= var_sh[VW-1:0];
                    sqres_reg <= '0;
                    sqbit_reg <= VW'(1) << (VW - 2);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (sqbit_reg == '0)
                    begin
                        std_reg   <= sqres_reg[MW-1:0];
                        iss_reg   <= '0;
                        ksum_reg  <= '0;
                        kcnt_reg  <= '0;
                        state_reg <= S_P2;
                    end
                    else
                    begin
                        if (sq_ge)
                        begin
                            sqv_reg   <= sqv_reg - sq_t[VW-1:0];
                            sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                        end
                        else
                        begin
                            sqres_reg <= sqres_reg >> 1;
                        end
                        sqbit_reg <= sqbit_reg >> 2;
                    end
                end
                S_P2:
                begin
                    if (iss_reg != N_CW)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    v1_reg <= (iss_reg != N_CW);
                    v2_reg <= v1_reg;
                    v3_reg <= v2_reg;
                    if (v1_reg)
                    begin
                        e_reg   <= e_abs;
                        kv1_reg <= rdata_reg;
                    end
                    if (v2_reg)
                    begin
                        esq_reg <= DW'(e_reg) * DW'(e_reg);
                        flr_reg <= (FW'(e_reg) <= flim);
                        kv2_reg <= kv1_reg;
                    end
                    if (v3_reg && keep)
                    begin
                        ksum_reg <= ksum_reg + SW'(kv2_reg);
                        kcnt_reg <= kcnt_reg + 1'b1;
                    end
                    if (pass_end)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    if (kcnt_low)
                    begin
                        fb_reg    <= 1'b1;
                        fmean_reg <= mean_reg;
                        kout_reg  <= FB_K;
                        state_reg <= S_OUT;
                    end
                    else if (kcnt_reg == '0)
                    begin
                        fb_reg    <= 1'b0;
                        fmean_reg <= '0;
                        kout_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        fb_reg    <= 1'b0;
                        kout_reg  <= kcnt_ext[KEPT_W-1:0];
                        state_reg <= S_DF_GO;
                    end
                end
                S_DF_GO:
                begin
                    state_reg <= S_DF_WAIT;
                end
                S_DF_WAIT:
                begin
                    if (div_done)
                    begin
                        fmean_reg <= div_quo[MW-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!outv_reg || !out_stall)
                    begin
                        outv_reg    <= 1'b1;
                        o_mean_reg  <= Q_W'(mean_reg);
                        o_min_reg   <= PORT_SW'(min_reg);
                        o_max_reg   <= PORT_SW'(max_reg);
                        o_std_reg   <= Q_W'(std_reg);
                        o_fmean_reg <= Q_W'(fmean_reg);
                        o_kept_reg  <= kout_reg;
                        o_fb_reg    <= fb_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = outv_reg;
    assign window_mean   = o_mean_reg;
    assign window_min    = o_min_reg;
    assign window_max    = o_max_reg;
    assign window_stdev  = o_std_reg;
    assign filtered_mean = o_fmean_reg;
    assign kept_count    = o_kept_reg;
    assign fell_back     = o_fb_reg;

endmodule

// ===== src/window_stats_outlier_reject.sv =====
`timescale 1ns / 1ps
// From input accept to result valid, each item takes two passes over the window memory,
// a square root and, unless it falls back or keeps nothing, the kept-mean divide. One item
// is worked on at a time: the next sample is not taken from the queue until the result
// for the last one has been loaded into the output registers.
// After reset the window memory is cleared, during which in_stall is high.
// ----------------------------------------------------------------------------
// window_stats_outlier_reject
// Sliding window mean, min, max, stdev and outlier-rejected mean of samples.
// ----------------------------------------------------------------------------
module window_stats_outlier_reject import wsor_pkg::*; #(
    parameter int SAMPLE_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PORT_SW-1:0] sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [Q_W-1:0]     window_mean,
    output logic [PORT_SW-1:0] window_min,
    output logic [PORT_SW-1:0] window_max,
    output logic [Q_W-1:0]     window_stdev,
    output logic [Q_W-1:0]     filtered_mean,
    output logic [KEPT_W-1:0]  kept_count,
    output logic               fell_back
);

    logic [FLOOR_W-1:0]     floor_reg;
    logic [KEPT_W-1:0]      minkept_reg;
    logic                   wr_en;
    logic                   push;
    logic [SAMPLE_BITS-1:0] push_data;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_data;
    logic                   q_full;
    logic                   q_empty;
    back_status_t           bstat;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_MINKEPT) ? 32'(minkept_reg) : 32'(floor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RST;
            minkept_reg <= MINKEPT_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_FLOOR)
            begin
                floor_reg <= pwdata[FLOOR_W-1:0];
            end
            else
            begin
                minkept_reg <= pwdata[KEPT_W-1:0];
            end
        end
    end

    wsor_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .q_full    (q_full),
        .bstat     (bstat),
        .push      (push),
        .push_data (push_data)
    );

    wsor_queue #(
        .W     (SAMPLE_BITS),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsor_back #(
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .bstat          (bstat),
        .outlier_floor  (floor_reg),
        .min_kept_count (minkept_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_mean    (window_mean),
        .window_min     (window_min),
        .window_max     (window_max),
        .window_stdev   (window_stdev),
        .filtered_mean  (filtered_mean),
        .kept_count     (kept_count),
        .fell_back      (fell_back)
    );

endmodule
